>>> rtl/rra_pkg.sv
// shared types and constants for the rate request aggregator
`default_nettype none

package rra_pkg;

    localparam int unsigned RATE_W = 32;
    localparam int unsigned REQ_W  = 2;

    localparam logic [RATE_W-1:0] RATE_ALL_ONES = {RATE_W{1'b1}};

    localparam logic ACT_SET_FLOOR   = 1'b0;
    localparam logic ACT_SET_CEILING = 1'b1;

    localparam logic STATUS_COMMITTED = 1'b0;
    localparam logic STATUS_REJECTED  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic last;
    } t_ctrl_sts;

endpackage

`default_nettype wire

>>> rtl/rra_ctrl.sv
// controller state machine: accept, walk the stored entries, finish
`default_nettype none

module rra_ctrl import rra_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_start,
    output logic       o_busy,
    output logic       o_done,
    output t_ctrl_cmd  o_cmd,
    input  t_ctrl_sts  i_sts
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_busy        = 1'b0;
        o_done        = 1'b0;
        o_cmd         = '0;
        accept        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                accept = i_start;
            end
            ST_WALK: begin
                o_busy     = 1'b1;
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // commit and report, and a new request may load at the same edge
                o_done       = 1'b1;
                o_cmd.finish = 1'b1;
                accept       = i_start;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (accept) begin
            o_cmd.load = 1'b1;
            n_state    = ST_WALK;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rra_datapath.sv
// request store, running max/min over the entries and commit logic
`default_nettype none

module rra_datapath import rra_pkg::*; #(
    parameter int unsigned NUM_REQUESTERS = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_ctrl_cmd        i_cmd,
    output t_ctrl_sts        o_sts,
    input  wire              i_action,
    input  wire [REQ_W-1:0]  i_requester,
    input  wire [RATE_W-1:0] i_rate_value,
    output logic             o_status,
    output logic [RATE_W-1:0] o_target_rate,
    output logic [RATE_W-1:0] o_ceiling_rate
);

    localparam int unsigned CNT_W = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_REQUESTERS - 1);

    logic [RATE_W-1:0] r_floor [NUM_REQUESTERS];
    logic [RATE_W-1:0] r_ceil  [NUM_REQUESTERS];

    logic              r_action;
    logic [REQ_W-1:0]  r_req;
    logic [RATE_W-1:0] r_rate;
    logic [CNT_W-1:0]  r_cnt;
    logic [RATE_W-1:0] r_agg_floor;
    logic [RATE_W-1:0] r_agg_ceil;

    logic              req_valid;
    logic              hit;
    logic [RATE_W-1:0] cur_floor;
    logic [RATE_W-1:0] cur_ceil;
    logic              reject;
    logic              commit;

    assign req_valid = (32'(r_req) < NUM_REQUESTERS);
    assign hit       = req_valid && (32'(r_cnt) == 32'(r_req));

    // the new request stands in for the stored entry of its requester
    always_comb begin
        cur_floor = r_floor[r_cnt];
        cur_ceil  = r_ceil[r_cnt];
        if (hit) begin
            if (r_action == ACT_SET_FLOOR) begin
                cur_floor = r_rate;
            end else begin
                cur_ceil = r_rate;
            end
        end
    end

    assign o_sts.last = (r_cnt == CNT_LAST);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action    <= i_action;
            r_req       <= i_requester;
            r_rate      <= i_rate_value;
            r_cnt       <= '0;
            r_agg_floor <= '0;
            r_agg_ceil  <= RATE_ALL_ONES;
        end else if (i_cmd.step) begin
            if (!o_sts.last) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (cur_floor > r_agg_floor) begin
                r_agg_floor <= cur_floor;
            end
            if (cur_ceil < r_agg_ceil) begin
                r_agg_ceil <= cur_ceil;
            end
        end
    end

    assign reject = (r_agg_floor > r_agg_ceil);
    assign commit = i_cmd.finish && req_valid && !reject;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_REQUESTERS; i++) begin
            if (!i_rst_n) begin
                r_floor[i] <= '0;
                r_ceil[i]  <= RATE_ALL_ONES;
            end else if (commit && (32'(r_req) == 32'(i))) begin
                if (r_action == ACT_SET_FLOOR) begin
                    r_floor[i] <= r_rate;
                end else begin
                    r_ceil[i] <= r_rate;
                end
            end
        end
    end

    assign o_status       = reject ? STATUS_REJECTED : STATUS_COMMITTED;
    assign o_target_rate  = r_agg_floor;
    assign o_ceiling_rate = r_agg_ceil;

endmodule

`default_nettype wire

>>> rtl/rate_request_aggregator_core.sv
// top level of the rate request aggregator: controller plus datapath
//
// channel   | ports                                          | handshake
// ----------+------------------------------------------------+---------------------------
// request   | i_action, i_requester, i_rate_value            | start high, busy low
// result    | o_status, o_target_rate, o_ceiling_rate        | o_done high for one cycle
//
// a request walks the NUM_REQUESTERS stored entries, one per cycle, then one
// finish cycle commits it and shows the result with o_done
// the next request may be taken in the finish cycle: NUM_REQUESTERS + 1 cycles
// per request, 5 with the default of four requesters
// synchronous active-low reset clears the store to floor zero, ceiling all ones
// the receiver cannot stall: every result is taken in the cycle it is shown
`default_nettype none

module rate_request_aggregator_core import rra_pkg::*; #(
    parameter int unsigned NUM_REQUESTERS = 4
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire               i_action,
    input  wire [REQ_W-1:0]   i_requester,
    input  wire [RATE_W-1:0]  i_rate_value,
    output logic              o_done,
    output logic              o_status,
    output logic [RATE_W-1:0] o_target_rate,
    output logic [RATE_W-1:0] o_ceiling_rate
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    rra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    rra_datapath #(
        .NUM_REQUESTERS (NUM_REQUESTERS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_requester    (i_requester),
        .i_rate_value   (i_rate_value),
        .o_status       (o_status),
        .o_target_rate  (o_target_rate),
        .o_ceiling_rate (o_ceiling_rate)
    );

    // an accepted request always goes into the walk
    a_accept_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start the walk");

    // a result only ever follows the walk
    a_done_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding walk");

    // the strobe lasts one cycle
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // a rejection means the reported floor lies above the reported ceiling
    a_reject_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == STATUS_REJECTED)) |-> (o_target_rate > o_ceiling_rate))
        else $error("rejected request with floor not above ceiling");

endmodule

`default_nettype wire

>>> test/rate_request_aggregator_core_tb.sv
// testbench for the rate request aggregator: directed corners, random requests, self-checking
`timescale 1ns / 100ps

module rate_request_aggregator_core_tb import rra_pkg::*; ();

    localparam int unsigned NUM_REQUESTERS = 4;
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned SETTLE_CYCLES  = NUM_REQUESTERS + 4;

    typedef struct packed {
        logic              status;
        logic [RATE_W-1:0] target_rate;
        logic [RATE_W-1:0] ceiling_rate;
    } t_rate_result;

    logic              i_clk;
    logic              i_rst_n        = 1'b0;
    logic              start          = 1'b0;
    logic              i_action       = ACT_SET_FLOOR;
    logic [REQ_W-1:0]  i_requester    = '0;
    logic [RATE_W-1:0] i_rate_value   = '0;
    logic              busy;
    logic              o_done;
    logic              o_status;
    logic [RATE_W-1:0] o_target_rate;
    logic [RATE_W-1:0] o_ceiling_rate;

    // own copy of the request store
    logic [RATE_W-1:0] floor_store   [NUM_REQUESTERS];
    logic [RATE_W-1:0] ceiling_store [NUM_REQUESTERS];

    t_rate_result expected_results[$];
    int unsigned  error_count = 0;
    int unsigned  cycle_count = 0;

    rate_request_aggregator_core #(
        .NUM_REQUESTERS(NUM_REQUESTERS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_requester    (i_requester),
        .i_rate_value   (i_rate_value),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_target_rate  (o_target_rate),
        .o_ceiling_rate (o_ceiling_rate)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic void clear_store();
        for (int i = 0; i < NUM_REQUESTERS; i++) begin
            floor_store[i]   = '0;
            ceiling_store[i] = RATE_ALL_ONES;
        end
    endfunction

    // highest floor and lowest ceiling with the new request in place; commit unless they cross
    function automatic t_rate_result apply_rate_request(input logic act,
                                                        input logic [REQ_W-1:0] who,
                                                        input logic [RATE_W-1:0] rate);
        t_rate_result      res;
        logic              in_range;
        logic [RATE_W-1:0] new_floor;
        logic [RATE_W-1:0] new_ceiling;
        logic [RATE_W-1:0] f;
        logic [RATE_W-1:0] c;
        in_range    = (who < NUM_REQUESTERS);
        new_floor   = '0;
        new_ceiling = RATE_ALL_ONES;
        if (in_range) begin
            new_floor   = floor_store[who];
            new_ceiling = ceiling_store[who];
            if (act == ACT_SET_FLOOR)
                new_floor = rate;
            else
                new_ceiling = rate;
        end
        res.target_rate  = '0;
        res.ceiling_rate = RATE_ALL_ONES;
        for (int i = 0; i < NUM_REQUESTERS; i++) begin
            f = floor_store[i];
            c = ceiling_store[i];
            if (in_range && i == who) begin
                f = new_floor;
                c = new_ceiling;
            end
            if (f > res.target_rate)
                res.target_rate = f;
            if (c < res.ceiling_rate)
                res.ceiling_rate = c;
        end
        res.status = (res.target_rate > res.ceiling_rate) ? STATUS_REJECTED : STATUS_COMMITTED;
        if (in_range && res.status == STATUS_COMMITTED) begin
            floor_store[who]   = new_floor;
            ceiling_store[who] = new_ceiling;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rate_result exp_res;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0b target=%h ceiling=%h",
                                          o_status, o_target_rate, o_ceiling_rate));
            end else begin
                exp_res = expected_results.pop_front();
                if (o_status !== exp_res.status)
                    report_mismatch($sformatf("status got %b exp %b",
                                              o_status, exp_res.status));
                if (o_target_rate !== exp_res.target_rate)
                    report_mismatch($sformatf("target_rate got %h exp %h",
                                              o_target_rate, exp_res.target_rate));
                if (o_ceiling_rate !== exp_res.ceiling_rate)
                    report_mismatch($sformatf("ceiling_rate got %h exp %h",
                                              o_ceiling_rate, exp_res.ceiling_rate));
            end
        end
    end

    // leaves start high so a following request can go straight in
    task automatic send_request(input logic act, input logic [REQ_W-1:0] who,
                                input logic [RATE_W-1:0] rate);
        start        <= 1'b1;
        i_action     <= act;
        i_requester  <= who;
        i_rate_value <= rate;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        expected_results.push_back(apply_rate_request(act, who, rate));
    endtask

    task automatic idle_for(input int unsigned cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    function automatic int unsigned random_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 6);
        else
            return $urandom_range(10, 40);
    endfunction

    // mostly small rates so floors and ceilings cross often, plus the extremes
    function automatic logic [RATE_W-1:0] random_rate(input logic act);
        case ($urandom_range(0, 9))
            0:       return (act == ACT_SET_FLOOR) ? '0 : RATE_ALL_ONES;
            1:       return $urandom();
            2:       return RATE_ALL_ONES - $urandom_range(0, 255);
            3:       return (act == ACT_SET_FLOOR) ? $urandom_range(0, 300)
                                                   : RATE_ALL_ONES;
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    task automatic wait_until_drained();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_corners();
        send_request(ACT_SET_FLOOR,   2'd0, '0);
        send_request(ACT_SET_CEILING, 2'd1, RATE_ALL_ONES);
        send_request(ACT_SET_FLOOR,   2'd2, RATE_ALL_ONES);
        // crossing limits must leave the store untouched
        send_request(ACT_SET_CEILING, 2'd3, '0);
        send_request(ACT_SET_CEILING, 2'd2, RATE_ALL_ONES - 1);
        send_request(ACT_SET_FLOOR,   2'd2, 32'd1000);
        // floor equal to ceiling is allowed
        send_request(ACT_SET_CEILING, 2'd3, 32'd1000);
        send_request(ACT_SET_FLOOR,   2'd1, 32'd1001);
        send_request(ACT_SET_FLOOR,   2'd1, 32'd1000);
        send_request(ACT_SET_CEILING, 2'd0, 32'd999);
        send_request(ACT_SET_FLOOR,   2'd2, '0);
        send_request(ACT_SET_FLOOR,   2'd1, '0);
        send_request(ACT_SET_CEILING, 2'd3, '0);
        send_request(ACT_SET_FLOOR,   2'd0, 32'd1);
        send_request(ACT_SET_CEILING, 2'd3, RATE_ALL_ONES);
        send_request(ACT_SET_FLOOR,   2'd0, 32'hAAAA_AAAA);
        send_request(ACT_SET_CEILING, 2'd1, 32'h5555_5555);
        send_request(ACT_SET_CEILING, 2'd1, 32'hAAAA_AAAA);
        send_request(ACT_SET_FLOOR,   2'd3, 32'h5555_5555);
        send_request(ACT_SET_CEILING, 2'd1, RATE_ALL_ONES);
        send_request(ACT_SET_FLOOR,   2'd0, '0);
        send_request(ACT_SET_FLOOR,   2'd3, '0);
    endtask

    task automatic test_back_to_back(input int unsigned count);
        logic act;
        for (int unsigned n = 0; n < count; n++) begin
            act = 1'($urandom_range(0, 1));
            send_request(act, REQ_W'($urandom_range(0, NUM_REQUESTERS - 1)), random_rate(act));
        end
    endtask

    task automatic test_random_gaps(input int unsigned count);
        logic act;
        for (int unsigned n = 0; n < count; n++) begin
            act = 1'($urandom_range(0, 1));
            send_request(act, REQ_W'($urandom_range(0, NUM_REQUESTERS - 1)), random_rate(act));
            idle_for(random_gap());
        end
    endtask

    initial begin
        clear_store();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_back_to_back(300);
        // hold the next request off until every result is back
        wait_until_drained();
        test_random_gaps(500);
        wait_until_drained();
        test_back_to_back(150);
        test_random_gaps(280);

        wait_until_drained();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
